// ===== rtl/smm_pkg.sv =====
// ============================================================================
// smm_pkg
// Shared types and constants for the square matrix multiplier.
// ============================================================================
package smm_pkg;

    // Default largest matrix side held in the operand memories
    localparam int SMM_MAX_DIM = 32;

    // Field widths fixed by the item format
    localparam int DATA_W = 32;
    localparam int IDX_W  = 5;
    localparam int CFG_W  = 3;

    // Side in use never exceeds 1 << 7, so a count of it fits in eight bits
    localparam int SIDE_W = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 3'd5;

    // Operation codes carried by a request item
    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Controls from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctl_t;

endpackage

// ===== rtl/smm_if.sv =====
// ============================================================================
// smm_if
// Valid/ready channels of the square matrix multiplier: request items,
// response items and the size configuration write.
// ============================================================================
interface smm_req_if import smm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    op_t                      operation;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output operation, output row, output col,
                    output value, input ready);
    modport sink   (input valid, input operation, input row, input col,
                    input value, output ready);
endinterface

interface smm_rsp_if import smm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] product;
    logic                     index_error;

    modport source (output valid, output product, output index_error, input ready);
    modport sink   (input valid, input product, input index_error, output ready);
endinterface

interface smm_cfg_if import smm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] size_log2;

    modport source (output valid, output size_log2, input ready);
    modport sink   (input valid, input size_log2, output ready);
endinterface

// ===== rtl/square_matrix_multiply.sv =====
// ============================================================================
// square_matrix_multiply
// Square integer matrix multiplier with element-wise load and read-out.
// ============================================================================
// A and B live in two MAX_DIM x MAX_DIM memories addressed row*MAX_DIM+col.
// A write item stores one element as it is accepted. A read item walks the
// dot product of row of A and column of B through one read port per memory
// and one multiply-accumulate per cycle (side = 1 << size_log2, clamped to
// 2..MAX_DIM); the memory read register and the product register lie
// between each read and its accumulation. An out-of-range write or read
// item answers with product zero and index_error set. Requests are taken
// one at a time; a finished response waits in its output register while
// the next request is accepted. Memories come up undefined and need no
// clearing pass: every element must be written before it is read. Change
// size_log2 only while no request is in flight.
// ============================================================================
module square_matrix_multiply import smm_pkg::*; #(
    parameter int MAX_DIM = SMM_MAX_DIM
) (
    input  logic      clk,
    input  logic      rst_n,
    smm_cfg_if.sink   cfg,
    smm_req_if.sink   req,
    smm_rsp_if.source rsp
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   size_log2_reg;
    logic [SIDE_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   col_reg, col_next;
    logic               err_reg, err_next;
    logic               rd_vld_reg;
    logic               rsp_vld_reg;
    logic [DATA_W-1:0]  rsp_prod_reg;
    logic               rsp_err_reg;

    logic [CFG_W-1:0]   exp_used;
    logic [SIDE_W-1:0]  side_full;
    logic [SIDE_W-1:0]  side;
    logic               bad;
    logic               req_fire;
    logic               wr_a;
    logic               wr_b;
    logic               issue;
    logic               load_out;
    logic               mac_busy;
    logic               clear;
    mac_ctl_t           mac_ctl;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      a_rd_addr;
    logic [AW-1:0]      b_rd_addr;
    logic [DATA_W-1:0]  a_data;
    logic [DATA_W-1:0]  b_data;
    logic [DATA_W-1:0]  acc;

    // Size register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= CFG_RESET;
        end
        else if (cfg.valid)
        begin
            size_log2_reg <= cfg.size_log2;
        end
    end

    // Side in use: at least 2, at most MAX_DIM
    assign exp_used  = (size_log2_reg == '0) ? CFG_W'(1) : size_log2_reg;
    assign side_full = SIDE_W'(1) << exp_used;
    assign side      = (32'(side_full) > MAX_DIM) ? SIDE_W'(MAX_DIM) : side_full;

    assign bad = (SIDE_W'(req.row) >= side) || (SIDE_W'(req.col) >= side);

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    // Element addresses
    assign wr_addr   = AW'(32'(req.row) * MAX_DIM + 32'(req.col));
    assign a_rd_addr = AW'(32'(row_reg) * MAX_DIM + 32'(k_reg));
    assign b_rd_addr = AW'(32'(k_reg) * MAX_DIM + 32'(col_reg));

    // Next state and sequencing controls
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        err_next   = err_reg;
        wr_a       = 1'b0;
        wr_b       = 1'b0;
        issue      = 1'b0;
        clear      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    priority if (req.operation == OP_NONE)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (bad)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        unique case (req.operation)
                            OP_WRITE_A: wr_a = 1'b1;
                            OP_WRITE_B: wr_b = 1'b1;
                            default:
                            begin
                                row_next   = req.row;
                                col_next   = req.col;
                                k_next     = '0;
                                err_next   = 1'b0;
                                clear      = 1'b1;
                                state_next = ST_RUN;
                            end
                        endcase
                    end
                end
            end
            ST_RUN:
            begin
                issue = 1'b1;
                if (k_reg == side - SIDE_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + SIDE_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
        end
    end

    // Hold read position and error flag
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        row_reg <= row_next;
        col_reg <= col_next;
        err_reg <= err_next;
    end

    // Operand memories
    smm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_W)
    ) u_left_ram (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (req.value),
        .rd_en   (issue),
        .rd_addr (a_rd_addr),
        .rd_data (a_data)
    );

    smm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_W)
    ) u_right_ram (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (req.value),
        .rd_en   (issue),
        .rd_addr (b_rd_addr),
        .rd_data (b_data)
    );

    // Multiply-accumulate on data returned by the memories
    assign mac_ctl.clear = clear;
    assign mac_ctl.valid = rd_vld_reg;

    smm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (a_data),
        .b     (b_data),
        .acc   (acc),
        .busy  (mac_busy)
    );

    // Response register: load when finished, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (load_out)
        begin
            rsp_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rsp_prod_reg <= err_reg ? '0 : acc;
            rsp_err_reg  <= err_reg;
        end
    end

    assign rsp.valid       = rsp_vld_reg;
    assign rsp.product     = $signed(rsp_prod_reg);
    assign rsp.index_error = rsp_err_reg;

    // No element is stored while a read is in progress
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (!wr_a && !wr_b))
        else $error("operand memory written outside idle");

    // The dot product index stays inside the side in use
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (k_reg < side))
        else $error("dot product index beyond side");

    // The multiply pipeline is busy only during a read
    a_mac_scope: assert property (@(posedge clk) disable iff (!rst_n)
        mac_busy |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("multiply pipeline active outside a read");

    // An index error always answers with a zero product
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.index_error) |-> (rsp.product == '0))
        else $error("index error with nonzero product");

endmodule

// ===== rtl/smm_ram.sv =====
// ============================================================================
// smm_ram
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data.
// ============================================================================
module smm_ram import smm_pkg::*; #(
    parameter int DEPTH = SMM_MAX_DIM * SMM_MAX_DIM,
    parameter int WIDTH = DATA_W
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Store on write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/smm_mac.sv =====
// ============================================================================
// smm_mac
// Multiply-accumulate unit: registered 32x32 product, then a wrapping
// 32-bit accumulate.
// ============================================================================
module smm_mac import smm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  mac_ctl_t          ctl,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [DATA_W-1:0] acc,
    output logic              busy
);

    logic [DATA_W-1:0] mul_reg;
    logic              mul_vld_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;

    // Low word of the product only; the sum wraps modulo 2^32
    always_ff @(posedge clk)
    begin
        mul_reg <= a * b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= ctl.valid;
        end
    end

    // Clear at the start of a read, add each product as it arrives
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (mul_vld_reg)
        begin
            acc_next = acc_reg + mul_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = ctl.valid || mul_vld_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for square_matrix_multiply. Loads elements of A and B,
// reads product elements and compares each one with a predictor that keeps
// its own copy of both matrices and of the size setting. Directed items cover
// value extremes, every operation, out-of-range items and size saturation.
// Random phases then walk through all size settings with idle and stall bursts.
// ============================================================================
module tb import smm_pkg::*;;

    localparam int MAX_SIDE       = SMM_MAX_DIM;
    // Quiet time before a size change, with margin over the longest read
    localparam int DRAIN_CYCLES   = SMM_MAX_DIM + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 100;
    localparam int PHASE_COUNT    = 15;

    typedef struct packed {
        logic [DATA_W-1:0] product;
        logic              index_error;
    } product_t;

    logic clk;
    logic rst_n;

    smm_cfg_if cfg_ch ();
    smm_req_if req_ch ();
    smm_rsp_if rsp_ch ();

    square_matrix_multiply u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predictor state: both operand matrices, written flags and the size
    logic [DATA_W-1:0] mat_a [0:MAX_SIDE*MAX_SIDE-1];
    logic [DATA_W-1:0] mat_b [0:MAX_SIDE*MAX_SIDE-1];
    bit                a_written [0:MAX_SIDE*MAX_SIDE-1];
    bit                b_written [0:MAX_SIDE*MAX_SIDE-1];
    logic [CFG_W-1:0]  size_exp;

    product_t pending_products [$];

    bit stall_enable;
    int mismatch_count;
    int items_sent;
    int settings_used;
    int results_checked;
    int range_errors_checked;
    int idle_cycles;

    // Clock: 2 ns period
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int side_of(logic [CFG_W-1:0] e);
        int s;
        s = (e < 1) ? 2 : (1 << e);
        return (s > MAX_SIDE) ? MAX_SIDE : s;
    endfunction

    // Update the matrices for one accepted item and queue its product, if any
    function automatic void apply_to_matrices(op_t op, logic [IDX_W-1:0] r,
                                              logic [IDX_W-1:0] c,
                                              logic [DATA_W-1:0] v);
        int          n;
        logic [DATA_W-1:0] acc;
        product_t    want;
        n = side_of(size_exp);
        if (op == OP_NONE)
            return;
        if (r >= n || c >= n)
        begin
            want.product     = '0;
            want.index_error = 1'b1;
            pending_products.push_back(want);
        end
        else if (op == OP_WRITE_A)
        begin
            mat_a[r*MAX_SIDE + c]     = v;
            a_written[r*MAX_SIDE + c] = 1'b1;
        end
        else if (op == OP_WRITE_B)
        begin
            mat_b[r*MAX_SIDE + c]     = v;
            b_written[r*MAX_SIDE + c] = 1'b1;
        end
        else
        begin
            acc = '0;
            for (int k = 0; k < n; k++)
                acc += mat_a[r*MAX_SIDE + k] * mat_b[k*MAX_SIDE + c];
            want.product     = acc;
            want.index_error = 1'b0;
            pending_products.push_back(want);
        end
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Send one request item; hold valid high across back-to-back items
    task automatic send_item(input op_t op, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c,
                             input logic [DATA_W-1:0] v);
        int gap;
        gap = 0;
        if (stall_enable && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.row       <= r;
        req_ch.col       <= c;
        req_ch.value     <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        apply_to_matrices(op, r, c, v);
        if (op != OP_NONE)
            items_sent++;
    endtask

    // Write every operand of A row r and B column c that is still unset
    task automatic load_missing_operands(input logic [IDX_W-1:0] r,
                                         input logic [IDX_W-1:0] c);
        int n;
        n = side_of(size_exp);
        for (int k = 0; k < n; k++)
        begin
            if (!a_written[r*MAX_SIDE + k])
                send_item(OP_WRITE_A, r, IDX_W'(k), random_word());
            if (!b_written[k*MAX_SIDE + c])
                send_item(OP_WRITE_B, IDX_W'(k), c, random_word());
        end
    endtask

    // Change the size only once the block has gone quiet
    task automatic write_size(input logic [CFG_W-1:0] e);
        req_ch.valid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.size_log2 <= e;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        size_exp = e;
        settings_used++;
    endtask

    task automatic random_item();
        int               n;
        int               pick;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        n    = side_of(size_exp);
        pick = $urandom_range(0, 99);
        r    = IDX_W'($urandom_range(0, n - 1));
        c    = IDX_W'($urandom_range(0, n - 1));
        if (pick < 5)
            send_item(OP_NONE, IDX_W'($urandom_range(0, MAX_SIDE - 1)),
                      IDX_W'($urandom_range(0, MAX_SIDE - 1)), random_word());
        else if (pick < 20 && n < MAX_SIDE)
        begin
            // Out of range on row, column or both
            case ($urandom_range(0, 2))
                0: r = IDX_W'($urandom_range(n, MAX_SIDE - 1));
                1: c = IDX_W'($urandom_range(n, MAX_SIDE - 1));
                default:
                begin
                    r = IDX_W'($urandom_range(n, MAX_SIDE - 1));
                    c = IDX_W'($urandom_range(n, MAX_SIDE - 1));
                end
            endcase
            send_item(op_t'($urandom_range(0, 2)), r, c, random_word());
        end
        else if (pick < 55)
            send_item($urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A, r, c,
                      random_word());
        else
        begin
            load_missing_operands(r, c);
            send_item(OP_READ, r, c, random_word());
        end
    endtask

    // Reset size is side 32: reach the top row and column indexes
    task automatic test_reset_size();
        load_missing_operands(5'd31, 5'd31);
        send_item(OP_READ, 5'd31, 5'd31, '0);
        load_missing_operands(5'd0, 5'd16);
        send_item(OP_READ, 5'd0, 5'd16, 32'hFFFF_FFFF);
        send_item(OP_NONE, 5'd31, 5'd31, 32'h1234_5678);
    endtask

    // Side 2 with extreme values, out-of-range items and the unused operation
    task automatic test_extremes_small();
        write_size(3'd1);
        send_item(OP_WRITE_A, 5'd0, 5'd0, 32'h7FFF_FFFF);
        send_item(OP_WRITE_A, 5'd0, 5'd1, 32'h8000_0000);
        send_item(OP_WRITE_A, 5'd1, 5'd0, 32'hFFFF_FFFF);
        send_item(OP_WRITE_A, 5'd1, 5'd1, 32'd1);
        send_item(OP_WRITE_B, 5'd0, 5'd0, 32'h7FFF_FFFF);
        send_item(OP_WRITE_B, 5'd0, 5'd1, 32'hFFFF_FFFF);
        send_item(OP_WRITE_B, 5'd1, 5'd0, 32'h8000_0000);
        send_item(OP_WRITE_B, 5'd1, 5'd1, 32'd2);
        send_item(OP_READ, 5'd0, 5'd0, '0);
        send_item(OP_READ, 5'd0, 5'd1, '0);
        send_item(OP_READ, 5'd1, 5'd0, '0);
        send_item(OP_READ, 5'd1, 5'd1, '0);
        send_item(OP_WRITE_A, 5'd2, 5'd0, 32'h5555_5555);
        send_item(OP_WRITE_B, 5'd0, 5'd31, 32'hAAAA_AAAA);
        send_item(OP_READ, 5'd31, 5'd31, '0);
        send_item(OP_READ, 5'd1, 5'd2, '0);
        send_item(OP_NONE, 5'd0, 5'd0, 32'hFFFF_FFFF);
        send_item(OP_READ, 5'd0, 5'd0, '0);
        // Exponent zero saturates to side 2
        write_size(3'd0);
        send_item(OP_READ, 5'd1, 5'd1, '0);
        send_item(OP_READ, 5'd2, 5'd1, '0);
        send_item(OP_WRITE_A, 5'd1, 5'd2, 32'h0F0F_0F0F);
    endtask

    // Random phases over every size setting, no idling in the last one
    task automatic test_random_sizes();
        logic [CFG_W-1:0] size_plan [0:PHASE_COUNT-1];
        int               stop_at;
        size_plan = '{3'd1, 3'd2, 3'd0, 3'd3, 3'd1, 3'd4, 3'd2, 3'd7,
                      3'd3, 3'd6, 3'd1, 3'd5, 3'd2, 3'd4, 3'd1};
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_size(size_plan[p]);
            stall_enable = (p != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at)
                random_item();
        end
    endtask

    // Response ready with random stall bursts
    initial
    begin : rsp_backpressure
        int hold;
        rsp_ch.ready = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp_ch.ready <= 1'b0;
            else if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_enable && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(0, 4);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expected product
    always @(posedge clk)
    begin : check_products
        product_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_products.size() == 0)
                report_mismatch($sformatf("unexpected result product=%h index_error=%b",
                                          rsp_ch.product, rsp_ch.index_error));
            else
            begin
                want = pending_products.pop_front();
                results_checked++;
                if (want.index_error)
                    range_errors_checked++;
                if (rsp_ch.product !== want.product)
                    report_mismatch($sformatf("product %h, expected %h",
                                              rsp_ch.product, want.product));
                if (rsp_ch.index_error !== want.index_error)
                    report_mismatch($sformatf("index_error %b, expected %b",
                                              rsp_ch.index_error, want.index_error));
            end
        end
    end

    // Drop the run if no channel moves an item for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_NONE;
        req_ch.row       = '0;
        req_ch.col       = '0;
        req_ch.value     = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.size_log2 = CFG_RESET;
        size_exp         = CFG_RESET;
        stall_enable     = 1'b1;
        mismatch_count   = 0;
        items_sent       = 0;
        settings_used    = 1;
        results_checked  = 0;
        range_errors_checked = 0;
        for (int i = 0; i < MAX_SIDE*MAX_SIDE; i++)
        begin
            a_written[i] = 1'b0;
            b_written[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_size();
        test_extremes_small();
        test_random_sizes();

        // Drain outstanding products, then let the pipeline settle
        req_ch.valid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items across %0d size settings (side 2 to 32, saturated too)",
                 items_sent, settings_used);
        $display("Checked %0d results, %0d of them out-of-range answers",
                 results_checked, range_errors_checked);
        if (mismatch_count == 0 && pending_products.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
